/* sv/dts_pkg.sv */
// Package for the dependency task scheduler: widths, command and status
// codes, the queued transaction type. No dependencies.
package dts_pkg;
  localparam int MAX_TASKS = 64;
  localparam int IDW       = $clog2(MAX_TASKS);
  localparam int CNTW      = $clog2(MAX_TASKS + 1);
  localparam int CMDW      = 3;
  localparam int STW       = 3;
  localparam int QDEPTH    = 2;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int QCW       = $clog2(QDEPTH + 1);

  localparam logic [CMDW-1:0] CMD_ADD  = 3'd0;
  localparam logic [CMDW-1:0] CMD_DEP  = 3'd1;
  localparam logic [CMDW-1:0] CMD_FIN  = 3'd2;
  localparam logic [CMDW-1:0] CMD_IRST = 3'd3;
  localparam logic [CMDW-1:0] CMD_POP  = 3'd4;
  localparam logic [CMDW-1:0] CMD_DONE = 3'd5;
  localparam logic [CMDW-1:0] CMD_CLR  = 3'd6;
  localparam logic [CMDW-1:0] CMD_QRY  = 3'd7;

  localparam logic [STW-1:0] ST_OK           = 3'd0;
  localparam logic [STW-1:0] ST_FROZEN       = 3'd1;
  localparam logic [STW-1:0] ST_NOT_FROZEN   = 3'd2;
  localparam logic [STW-1:0] ST_BAD_ID       = 3'd3;
  localparam logic [STW-1:0] ST_SELF         = 3'd4;
  localparam logic [STW-1:0] ST_FULL         = 3'd5;
  localparam logic [STW-1:0] ST_NONE         = 3'd6;
  localparam logic [STW-1:0] ST_NOT_ASSIGNED = 3'd7;

  typedef enum logic [2:0] {
    OP_ADD, OP_DEP, OP_FIN, OP_IRST, OP_POP, OP_DONE, OP_CLR, OP_QRY
  } op_t;

  typedef struct packed {
    op_t            op;
    logic [IDW-1:0] tid;
    logic [IDW-1:0] did;
    logic           same;
  } item_t;
endpackage

/* sv/dts_if.sv */
// Handshake interfaces for the command and result channels.
// Depends on dts_pkg.
interface dts_in_if;
  logic                     valid;
  logic                     ready;
  logic [dts_pkg::CMDW-1:0] cmd;
  logic [dts_pkg::IDW-1:0]  task_id;
  logic [dts_pkg::IDW-1:0]  prereq_id;
  modport source (output valid, cmd, task_id, prereq_id, input ready);
  modport sink   (input valid, cmd, task_id, prereq_id, output ready);
endinterface

interface dts_out_if;
  logic                     valid;
  logic                     ready;
  logic [dts_pkg::STW-1:0]  status;
  logic [dts_pkg::IDW-1:0]  result_task;
  logic [dts_pkg::CNTW-1:0] ready_count;
  logic [dts_pkg::CNTW-1:0] pending_count;
  logic [dts_pkg::CNTW-1:0] assigned_count;
  logic                     completed;
  logic                     available;
  logic [dts_pkg::CNTW-1:0] task_total;
  logic                     finalised_flag;
  modport source (output valid, status, result_task, ready_count, pending_count,
                  assigned_count, completed, available, task_total, finalised_flag,
                  input ready);
  modport sink   (input valid, status, result_task, ready_count, pending_count,
                  assigned_count, completed, available, task_total, finalised_flag,
                  output ready);
endinterface

/* sv/dependency_task_scheduler_unit.sv */
// Dependency task scheduler top level: front end, queue, back end.
// Add, clear, query and errors finish at decode; pop and add dependency take one further
// state; done reads the child row, then scans every registered task with a write-back
// state per dependent; finalise and iteration reset copy one RAM row a step. Commands
// queue while the back end executes one at a time. Reset (rst_n, synchronous) empties
// the graph; RAM contents are not cleared. Depends on dts_pkg, dts_if, dts_front/fifo/back.
module dependency_task_scheduler_unit (
  input  logic       clk,
  input  logic       rst_n,
  dts_in_if.sink     in_ch,
  dts_out_if.source  out_ch
);
  import dts_pkg::*;

  item_t st_item, q_data;
  logic  st_valid, st_take, q_valid, q_pop;

  dts_front u_front (
    .clk, .rst_n, .in_ch, .st_item, .st_valid, .st_take);

  dts_fifo u_fifo (
    .clk, .rst_n, .push_valid(st_valid), .push_ready(st_take),
    .push_data(st_item), .pop_valid(q_valid), .pop(q_pop), .pop_data(q_data));

  dts_back u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_pop, .out_ch);

  a_rdy_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.ready_count <= CNTW'(MAX_TASKS))
    else $error("ready count above table size");

  a_unfrozen_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.finalised_flag |->
      out_ch.ready_count == '0 && out_ch.assigned_count == '0 &&
      out_ch.pending_count == '0)
    else $error("iteration state outside a frozen graph");

  a_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ({2'b0, out_ch.ready_count} + {2'b0, out_ch.pending_count} +
      {2'b0, out_ch.assigned_count}) <= {2'b0, out_ch.task_total})
    else $error("task sets exceed task total");
endmodule

/* sv/dts_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module dts_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] wa,
  input  logic [W-1:0]         wd,
  input  logic [$clog2(D)-1:0] ra,
  output logic [W-1:0]         rd
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  assign rd = rd_r;
endmodule

/* sv/dts_front.sv */
// Front end: accepts command transactions, decodes them into queue items.
// Depends on dts_pkg and dts_if.
module dts_front (
  input  logic           clk,
  input  logic           rst_n,
  dts_in_if.sink         in_ch,
  output dts_pkg::item_t st_item,
  output logic           st_valid,
  input  logic           st_take
);
  import dts_pkg::*;

  logic  st_valid_r, st_valid_nxt;
  item_t st_r;
  item_t dec;

  assign in_ch.ready = !st_valid_r || st_take;

  always_comb begin
    dec.tid  = in_ch.task_id;
    dec.did  = in_ch.prereq_id;
    dec.same = in_ch.task_id == in_ch.prereq_id;
    unique case (in_ch.cmd)
      CMD_ADD:  dec.op = OP_ADD;
      CMD_DEP:  dec.op = OP_DEP;
      CMD_FIN:  dec.op = OP_FIN;
      CMD_IRST: dec.op = OP_IRST;
      CMD_POP:  dec.op = OP_POP;
      CMD_DONE: dec.op = OP_DONE;
      CMD_CLR:  dec.op = OP_CLR;
      CMD_QRY:  dec.op = OP_QRY;
      default:  dec.op = OP_QRY;
    endcase
  end

  always_comb begin
    st_valid_nxt = st_valid_r;
    if (in_ch.valid && in_ch.ready) begin
      st_valid_nxt = 1'b1;
    end else if (st_take) begin
      st_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= st_valid_nxt;
    end
    if (in_ch.valid && in_ch.ready) begin
      st_r <= dec;
    end
  end

  assign st_item  = st_r;
  assign st_valid = st_valid_r;
endmodule

/* sv/dts_fifo.sv */
// Short queue between the front end and the execution back end.
// Depends on dts_pkg.
module dts_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  dts_pkg::item_t push_data,
  output logic           pop_valid,
  input  logic           pop,
  output dts_pkg::item_t pop_data
);
  import dts_pkg::*;

  item_t          q_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign push_ready = cnt_r != QCW'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = q_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wp_nxt  = do_push ? ((wp_r == QAW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = do_pop ? ((rp_r == QAW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + QCW'(do_push) - QCW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      q_r[wp_r] <= push_data;
    end
  end
endmodule

/* sv/dts_back.sv */
// Back end: executes queued commands against the task graph, the ready
// stack and the per-iteration state. Depends on dts_pkg, dts_if, dts_ram.
module dts_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  dts_pkg::item_t q_data,
  output logic           q_pop,
  dts_out_if.source      out_ch
);
  import dts_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CP_RD  = 8'b0000_0010,
    S_CP_WR  = 8'b0000_0100,
    S_AD_WR  = 8'b0000_1000,
    S_POP_RD = 8'b0001_0000,
    S_DN_CH  = 8'b0010_0000,
    S_DN_SCN = 8'b0100_0000,
    S_DN_WB  = 8'b1000_0000
  } state_t;

  // Completion is folded into a flag; the result waits in it and blocks decode until the output is free
  state_t                state_r, state_nxt;
  logic                  fin_r, fin_nxt;
  logic [CNTW-1:0]       total_r, total_nxt;
  logic                  frozen_r, frozen_nxt;
  logic [MAX_TASKS-1:0]  root_r, root_nxt;
  logic [CNTW-1:0]       depth_r, depth_nxt;
  logic [MAX_TASKS-1:0]  asg_r, asg_nxt;
  logic [MAX_TASKS-1:0]  pend_r, pend_nxt;
  logic [CNTW-1:0]       pcnt_r, pcnt_nxt;
  logic [CNTW-1:0]       acnt_r, acnt_nxt;
  logic [CNTW-1:0]       idx_r, idx_nxt;
  logic [MAX_TASKS-1:0]  crow_r, crow_nxt;
  item_t                 op_r, op_nxt;
  logic [STW-1:0]        st_r, st_nxt;
  logic [IDW-1:0]        res_r, res_nxt;

  logic                  ov_r, ov_nxt;
  logic [STW-1:0]        o_st_r;
  logic [IDW-1:0]        o_res_r;
  logic [CNTW-1:0]       o_rdy_r, o_pend_r, o_asg_r, o_tot_r;
  logic                  o_fz_r;

  logic                  par_we, chd_we, wt_we, stk_we;
  logic [IDW-1:0]        par_wa, chd_wa, wt_wa, stk_wa;
  logic [IDW-1:0]        par_ra, chd_ra, wt_ra, stk_ra;
  logic [MAX_TASKS-1:0]  par_wd, chd_wd, wt_wd, par_rd, chd_rd, wt_rd, wt_new;
  logic [IDW-1:0]        stk_wd, stk_rd;
  logic                  out_free;

  dts_ram #(.W(MAX_TASKS), .D(MAX_TASKS)) u_par (
    .clk, .we(par_we), .wa(par_wa), .wd(par_wd), .ra(par_ra), .rd(par_rd));
  dts_ram #(.W(MAX_TASKS), .D(MAX_TASKS)) u_chd (
    .clk, .we(chd_we), .wa(chd_wa), .wd(chd_wd), .ra(chd_ra), .rd(chd_rd));
  dts_ram #(.W(MAX_TASKS), .D(MAX_TASKS)) u_wt (
    .clk, .we(wt_we), .wa(wt_wa), .wd(wt_wd), .ra(wt_ra), .rd(wt_rd));
  dts_ram #(.W(IDW), .D(MAX_TASKS)) u_stk (
    .clk, .we(stk_we), .wa(stk_wa), .wd(stk_wd), .ra(stk_ra), .rd(stk_rd));

  assign out_free = !ov_r || out_ch.ready;
  assign wt_new   = wt_rd & ~(MAX_TASKS'(1) << op_r.tid);

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = 1'b0;
    total_nxt = total_r;
    frozen_nxt = frozen_r;
    root_nxt  = root_r;
    depth_nxt = depth_r;
    asg_nxt   = asg_r;
    pend_nxt  = pend_r;
    pcnt_nxt  = pcnt_r;
    acnt_nxt  = acnt_r;
    idx_nxt   = idx_r;
    crow_nxt  = crow_r;
    op_nxt    = op_r;
    st_nxt    = st_r;
    res_nxt   = res_r;
    q_pop     = 1'b0;
    par_we = 1'b0; par_wa = op_r.tid; par_wd = '0; par_ra = op_r.tid;
    chd_we = 1'b0; chd_wa = op_r.did; chd_wd = '0; chd_ra = op_r.did;
    wt_we  = 1'b0; wt_wa  = idx_r[IDW-1:0]; wt_wd = wt_rd; wt_ra = idx_r[IDW-1:0];
    stk_we = 1'b0; stk_wa = depth_r[IDW-1:0]; stk_wd = idx_r[IDW-1:0];
    stk_ra = depth_r[IDW-1:0] - 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid && !fin_r) begin
          q_pop   = 1'b1;
          op_nxt  = q_data;
          st_nxt  = ST_OK;
          res_nxt = '0;
          fin_nxt = 1'b1;
          unique case (q_data.op)
            OP_ADD: begin
              if (frozen_r) begin
                st_nxt = ST_FROZEN;
              end else if (total_r == CNTW'(MAX_TASKS)) begin
                st_nxt = ST_FULL;
              end else begin
                res_nxt = total_r[IDW-1:0];
                par_we = 1'b1; par_wa = total_r[IDW-1:0];
                chd_we = 1'b1; chd_wa = total_r[IDW-1:0];
                root_nxt[total_r[IDW-1:0]] = 1'b1;
                total_nxt = total_r + 1'b1;
              end
            end
            OP_DEP: begin
              if ({1'b0, q_data.tid} >= total_r || {1'b0, q_data.did} >= total_r) begin
                st_nxt = ST_BAD_ID;
              end else if (q_data.same) begin
                st_nxt = ST_SELF;
              end else if (frozen_r) begin
                st_nxt = ST_FROZEN;
              end else begin
                par_ra    = q_data.tid;
                chd_ra    = q_data.did;
                fin_nxt   = 1'b0;
                state_nxt = S_AD_WR;
              end
            end
            OP_FIN, OP_IRST: begin
              if (q_data.op == OP_IRST && !frozen_r) begin
                st_nxt = ST_NOT_FROZEN;
              end else begin
                frozen_nxt = 1'b1;
                asg_nxt = '0; pend_nxt = '0; pcnt_nxt = '0; acnt_nxt = '0;
                depth_nxt = '0; idx_nxt = '0;
                if (total_r != '0) begin
                  fin_nxt   = 1'b0;
                  state_nxt = S_CP_RD;
                end
              end
            end
            OP_POP: begin
              if (!frozen_r) begin
                st_nxt = ST_NOT_FROZEN;
              end else if (depth_r == '0) begin
                st_nxt = ST_NONE;
              end else begin
                depth_nxt = depth_r - 1'b1;
                fin_nxt   = 1'b0;
                state_nxt = S_POP_RD;
              end
            end
            OP_DONE: begin
              if (!frozen_r) begin
                st_nxt = ST_NOT_FROZEN;
              end else if ({1'b0, q_data.tid} >= total_r || !asg_r[q_data.tid]) begin
                st_nxt = ST_NOT_ASSIGNED;
              end else begin
                asg_nxt[q_data.tid] = 1'b0;
                acnt_nxt  = acnt_r - 1'b1;
                chd_ra    = q_data.tid;
                fin_nxt   = 1'b0;
                state_nxt = S_DN_CH;
              end
            end
            OP_CLR: begin
              total_nxt = '0; frozen_nxt = 1'b0; root_nxt = '0; depth_nxt = '0;
              asg_nxt = '0; pend_nxt = '0; pcnt_nxt = '0; acnt_nxt = '0;
            end
            OP_QRY: begin
              if (!frozen_r) begin
                st_nxt = ST_NOT_FROZEN;
              end
            end
            default: st_nxt = ST_OK;
          endcase
        end else if (fin_r && !out_free) begin
          fin_nxt = 1'b1;
        end
      end
      S_AD_WR: begin
        par_we = 1'b1; par_wd = par_rd | (MAX_TASKS'(1) << op_r.did);
        chd_we = 1'b1; chd_wd = chd_rd | (MAX_TASKS'(1) << op_r.tid);
        root_nxt[op_r.tid] = 1'b0;
        fin_nxt   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CP_RD: begin
        par_ra = idx_r[IDW-1:0];
        if (root_r[idx_r[IDW-1:0]]) begin
          stk_we    = 1'b1;
          depth_nxt = depth_r + 1'b1;
        end else begin
          pend_nxt[idx_r[IDW-1:0]] = 1'b1;
          pcnt_nxt = pcnt_r + 1'b1;
        end
        state_nxt = S_CP_WR;
      end
      S_CP_WR: begin
        wt_we = 1'b1; wt_wd = par_rd;
        idx_nxt = idx_r + 1'b1;
        if (idx_r + 1'b1 == total_r) begin
          fin_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_CP_RD;
        end
      end
      S_POP_RD: begin
        res_nxt = stk_rd;
        asg_nxt[stk_rd] = 1'b1;
        acnt_nxt  = acnt_r + 1'b1;
        fin_nxt   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DN_CH: begin
        crow_nxt  = chd_rd;
        idx_nxt   = '0;
        state_nxt = S_DN_SCN;
      end
      S_DN_SCN: begin
        if (idx_r == total_r) begin
          fin_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else if (crow_r[idx_r[IDW-1:0]]) begin
          state_nxt = S_DN_WB;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DN_WB: begin
        wt_we = 1'b1; wt_wd = wt_new;
        if (wt_new == '0) begin
          if (depth_r < CNTW'(MAX_TASKS)) begin
            stk_we    = 1'b1;
            depth_nxt = depth_r + 1'b1;
          end
          if (pend_r[idx_r[IDW-1:0]]) begin
            pcnt_nxt = pcnt_r - 1'b1;
          end
          pend_nxt[idx_r[IDW-1:0]] = 1'b0;
        end
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_DN_SCN;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r && !out_ch.ready;
    if (fin_r && out_free) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fin_r    <= 1'b0;
      total_r  <= '0;
      frozen_r <= 1'b0;
      root_r   <= '0;
      depth_r  <= '0;
      asg_r    <= '0;
      pend_r   <= '0;
      pcnt_r   <= '0;
      acnt_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fin_r    <= fin_nxt;
      total_r  <= total_nxt;
      frozen_r <= frozen_nxt;
      root_r   <= root_nxt;
      depth_r  <= depth_nxt;
      asg_r    <= asg_nxt;
      pend_r   <= pend_nxt;
      pcnt_r   <= pcnt_nxt;
      acnt_r   <= acnt_nxt;
      ov_r     <= ov_nxt;
    end
    idx_r  <= idx_nxt;
    crow_r <= crow_nxt;
    op_r   <= op_nxt;
    st_r   <= st_nxt;
    res_r  <= res_nxt;
    if (fin_r && out_free) begin
      o_st_r   <= st_r;
      o_res_r  <= res_r;
      o_rdy_r  <= depth_r;
      o_pend_r <= pcnt_r;
      o_asg_r  <= acnt_r;
      o_tot_r  <= total_r;
      o_fz_r   <= frozen_r;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.status         = o_st_r;
  assign out_ch.result_task    = o_res_r;
  assign out_ch.ready_count    = o_rdy_r;
  assign out_ch.pending_count  = o_pend_r;
  assign out_ch.assigned_count = o_asg_r;
  assign out_ch.completed      = (o_rdy_r == '0) && (o_pend_r == '0) && (o_asg_r == '0);
  assign out_ch.available      = o_rdy_r != '0;
  assign out_ch.task_total     = o_tot_r;
  assign out_ch.finalised_flag = o_fz_r;
endmodule
